// ===== hw/rtl/json_base64_field_extractor_core_assert.svh =====
// Assertion macros for the base64 field extractor
`ifndef JSON_BASE64_FIELD_EXTRACTOR_CORE_ASSERT_SVH
`define JSON_BASE64_FIELD_EXTRACTOR_CORE_ASSERT_SVH

// ante holds in this cycle implies cons in this cycle
`define JBFE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jbfe assertion failed");

// ante holds in this cycle implies cons in the next cycle
`define JBFE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jbfe assertion failed");

`endif

// ===== hw/rtl/jbfe_pkg.sv =====
// Shared types, constants and helper functions of the base64 field extractor
`timescale 1ns / 1ps
package jbfe_pkg;

  localparam int unsigned HeadThreshold = 8;
  localparam int unsigned HeadDepth     = 16;
  localparam int unsigned KeyLen        = 10;
  localparam int unsigned CmdDepth      = 4;
  localparam int unsigned ResDepth      = 4;
  localparam int unsigned CmdPtrW       = $clog2(CmdDepth);
  localparam int unsigned CmdCntW       = $clog2(CmdDepth + 1);
  localparam int unsigned ResPtrW       = $clog2(ResDepth);
  localparam int unsigned ResCntW       = $clog2(ResDepth + 1);
  localparam int unsigned HeadIdxW      = $clog2(HeadDepth);
  localparam int unsigned HeadCntW      = $clog2(HeadDepth + 1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [7:0] MAGIC_FF  = 8'hFF;
  localparam logic [7:0] MAGIC_D8  = 8'hD8;
  localparam logic [7:0] MAGIC_89  = 8'h89;
  localparam logic [7:0] MAGIC_P   = 8'h50;
  localparam logic [7:0] MAGIC_N   = 8'h4E;
  localparam logic [7:0] MAGIC_G   = 8'h47;
  localparam logic [7:0] MAGIC_R   = 8'h52;
  localparam logic [7:0] MAGIC_I   = 8'h49;
  localparam logic [7:0] MAGIC_F   = 8'h46;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_TAG    = 2'd1,
    KIND_STATUS = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    FMT_JPG  = 2'd0,
    FMT_PNG  = 2'd1,
    FMT_WEBP = 2'd2,
    FMT_BIN  = 2'd3
  } format_e;

  typedef enum logic [3:0] {
    STAT_OK         = 4'd0,
    STAT_NO_COLON   = 4'd1,
    STAT_NULL       = 4'd2,
    STAT_NOT_STRING = 4'd3,
    STAT_BAD_CHAR   = 4'd4,
    STAT_BAD_LENGTH = 4'd5,
    STAT_DECODE_ERR = 4'd6,
    STAT_NO_KEY     = 4'd7,
    STAT_TRUNCATED  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_AFTER = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    OP_PLAIN = 2'd0,
    OP_HOLD  = 2'd1,
    OP_OPEN  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STEP_WRITE  = 3'd0,
    STEP_TAG    = 3'd1,
    STEP_HEAD   = 3'd2,
    STEP_BYTE   = 3'd3,
    STEP_STATUS = 3'd4
  } step_e;

  typedef struct packed {
    op_e                 op;
    logic [1:0]          nbytes;
    logic [2:0][7:0]     bytes;
    logic [HeadCntW-1:0] base;
    logic                stat_vld;
    status_e             stat;
  } cmd_t;

  typedef struct packed {
    out_kind_e  kind;
    logic [7:0] data;
    format_e    fmt;
    status_e    stat;
    logic       last;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd64;
    if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == CH_PLUS) v = 7'd62;
    else if (c == CH_SLASH) v = 7'd63;
    return v;
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = CH_QUOTE;
      4'd1:    c = 8'h62;
      4'd2:    c = 8'h36;
      4'd3:    c = 8'h34;
      4'd4:    c = CH_UNDER;
      4'd5:    c = 8'h6A;
      4'd6:    c = 8'h73;
      4'd7:    c = 8'h6F;
      4'd8:    c = CH_LC_N;
      4'd9:    c = CH_QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/jbfe_cmd_queue.sv =====
// Command queue between the parser front and the result sequencer
`timescale 1ns / 1ps
module jbfe_cmd_queue
  import jbfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic vld_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t                entry_q [CmdDepth];
  logic [CmdPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0]  cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign vld_o   = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_comb begin
    wr_ptr_d = do_push ? CmdPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? CmdPtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = CmdCntW'(cnt_q + 1'b1);
    else if (do_pop && !do_push) cnt_d = CmdCntW'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/jbfe_front.sv =====
// Parser front: key scan, value framing and base64 quad decode into commands
`timescale 1ns / 1ps
module jbfe_front
  import jbfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_vld_i,
  input  logic       kind_i,
  input  logic [7:0] byte_i,
  output logic       cmd_vld_o,
  output cmd_t       cmd_o
);

  typedef struct packed {
    logic            err;
    logic [1:0]      len;
    logic [2:0][7:0] bytes;
  } dec_t;

  function automatic dec_t decode_quad(input logic [3:0][7:0] q);
    dec_t       d;
    logic [3:0] eq;
    logic [6:0] sx;
    logic [23:0] word;
    d    = '0;
    eq   = '0;
    word = '0;
    for (int i = 0; i < 4; i++) begin
      eq[i] = (q[i] == CH_EQ);
      sx    = sextet(q[i]);
      if (!eq[i] && sx[6]) d.err = 1'b1;
      word[23-6*i -: 6] = eq[i] ? 6'd0 : sx[5:0];
    end
    if (!(eq == 4'b0000 || eq == 4'b1000 || eq == 4'b1100)) d.err = 1'b1;
    d.len      = (eq == 4'b0000) ? 2'd3 : ((eq == 4'b1000) ? 2'd2 : 2'd1);
    d.bytes[0] = word[23:16];
    d.bytes[1] = word[15:8];
    d.bytes[2] = word[7:0];
    return d;
  endfunction

  phase_e              phase_q, phase_d;
  logic [3:0]          key_pos_q, key_pos_d;
  logic                colon_q, colon_d;
  logic [7:0]          quad_q [3];
  logic [1:0]          qc_q, qc_d;
  logic                quad_we;
  logic [HeadCntW-1:0] head_cnt_q, head_cnt_d;
  logic                opened_q, opened_d;
  logic                finished_q, finished_d;
  logic                failed_q, failed_d;

  logic                active, end_mark, sp, key_hit, key_done;
  logic                v_quote, v_bad, open_val;
  logic [7:0]          norm;
  logic [6:0]          norm_sx;
  logic [3:0][7:0]     qa;
  dec_t                dec;
  logic [HeadCntW-1:0] fl_sum;
  logic                fl_opens;
  op_e                 fl_op;

  assign end_mark = in_vld_i && kind_i;
  assign active   = in_vld_i && !kind_i && !failed_q && !finished_q;
  assign sp       = is_space(byte_i);
  assign key_hit  = (byte_i == key_char(key_pos_q));
  assign key_done = key_hit && (key_pos_q == 4'(KeyLen - 1));
  assign open_val = colon_q && !sp && (byte_i == CH_QUOTE);
  assign v_quote  = (byte_i == CH_QUOTE);

  always_comb begin
    norm = byte_i;
    if (byte_i == CH_MINUS) norm = CH_PLUS;
    else if (byte_i == CH_UNDER) norm = CH_SLASH;
  end

  assign norm_sx = sextet(norm);
  assign v_bad   = (norm != CH_EQ) && norm_sx[6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qa[i] = (v_quote && (2'(i) >= qc_q)) ? CH_EQ : quad_q[i];
    end
    qa[3] = v_quote ? CH_EQ : norm;
  end

  assign dec      = decode_quad(qa);
  assign fl_sum   = HeadCntW'(head_cnt_q + HeadCntW'(dec.len));
  assign fl_opens = !opened_q && (fl_sum >= HeadCntW'(HeadThreshold));
  assign fl_op    = opened_q ? OP_PLAIN : (fl_opens ? OP_OPEN : OP_HOLD);

  always_comb begin
    phase_d = phase_q;
    if (end_mark) begin
      phase_d = PH_HUNT;
    end else if (active) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (key_done) phase_d = PH_AFTER;
        end
        PH_AFTER: begin
          if (open_val) phase_d = PH_VALUE;
        end
        PH_VALUE: begin
          phase_d = PH_VALUE;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    key_pos_d  = key_pos_q;
    colon_d    = colon_q;
    qc_d       = qc_q;
    quad_we    = 1'b0;
    head_cnt_d = head_cnt_q;
    opened_d   = opened_q;
    finished_d = finished_q;
    failed_d   = failed_q;
    cmd_vld_o  = 1'b0;
    cmd_o      = '0;
    if (end_mark) begin
      if (!failed_q && !finished_q) begin
        cmd_vld_o    = 1'b1;
        cmd_o.stat_vld = 1'b1;
        cmd_o.stat   = (phase_q == PH_VALUE) ? STAT_TRUNCATED : STAT_NO_KEY;
      end
      key_pos_d  = '0;
      colon_d    = 1'b0;
      qc_d       = '0;
      head_cnt_d = '0;
      opened_d   = 1'b0;
      finished_d = 1'b0;
      failed_d   = 1'b0;
    end else if (active) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (key_done) begin
            key_pos_d = '0;
            colon_d   = 1'b0;
          end else if (key_hit) begin
            key_pos_d = 4'(key_pos_q + 1'b1);
          end else begin
            key_pos_d = (byte_i == CH_QUOTE) ? 4'd1 : 4'd0;
          end
        end
        PH_AFTER: begin
          if (!sp) begin
            if (!colon_q) begin
              if (byte_i != CH_COLON) begin
                failed_d       = 1'b1;
                cmd_vld_o      = 1'b1;
                cmd_o.stat_vld = 1'b1;
                cmd_o.stat     = STAT_NO_COLON;
              end else begin
                colon_d = 1'b1;
              end
            end else if (byte_i == CH_LC_N) begin
              failed_d       = 1'b1;
              cmd_vld_o      = 1'b1;
              cmd_o.stat_vld = 1'b1;
              cmd_o.stat     = STAT_NULL;
            end else if (byte_i != CH_QUOTE) begin
              failed_d       = 1'b1;
              cmd_vld_o      = 1'b1;
              cmd_o.stat_vld = 1'b1;
              cmd_o.stat     = STAT_NOT_STRING;
            end
          end
        end
        PH_VALUE: begin
          if (v_quote) begin
            qc_d = '0;
            if (qc_q == 2'd1) begin
              failed_d       = 1'b1;
              cmd_vld_o      = 1'b1;
              cmd_o.stat_vld = 1'b1;
              cmd_o.stat     = STAT_BAD_LENGTH;
            end else if (qc_q != 2'd0 && dec.err) begin
              failed_d       = 1'b1;
              cmd_vld_o      = 1'b1;
              cmd_o.stat_vld = 1'b1;
              cmd_o.stat     = STAT_DECODE_ERR;
            end else begin
              finished_d     = 1'b1;
              cmd_vld_o      = 1'b1;
              cmd_o.stat_vld = 1'b1;
              cmd_o.stat     = opened_q ? STAT_OK : STAT_TRUNCATED;
              if (qc_q != 2'd0) begin
                cmd_o.op     = fl_op;
                cmd_o.nbytes = dec.len;
                cmd_o.bytes  = dec.bytes;
                cmd_o.base   = head_cnt_q;
                cmd_o.stat   = (opened_q || fl_opens) ? STAT_OK : STAT_TRUNCATED;
                if (!opened_q) head_cnt_d = fl_sum;
                if (fl_opens) opened_d = 1'b1;
              end
            end
          end else if (!sp) begin
            if (v_bad) begin
              failed_d       = 1'b1;
              cmd_vld_o      = 1'b1;
              cmd_o.stat_vld = 1'b1;
              cmd_o.stat     = STAT_BAD_CHAR;
            end else if (qc_q == 2'd3) begin
              qc_d = '0;
              if (dec.err) begin
                failed_d       = 1'b1;
                cmd_vld_o      = 1'b1;
                cmd_o.stat_vld = 1'b1;
                cmd_o.stat     = STAT_DECODE_ERR;
              end else begin
                cmd_vld_o    = 1'b1;
                cmd_o.op     = fl_op;
                cmd_o.nbytes = dec.len;
                cmd_o.bytes  = dec.bytes;
                cmd_o.base   = head_cnt_q;
                if (!opened_q) head_cnt_d = fl_sum;
                if (fl_opens) opened_d = 1'b1;
              end
            end else begin
              quad_we = 1'b1;
              qc_d    = 2'(qc_q + 1'b1);
            end
          end
        end
        default: begin
          key_pos_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      key_pos_q  <= '0;
      colon_q    <= 1'b0;
      qc_q       <= '0;
      head_cnt_q <= '0;
      opened_q   <= 1'b0;
      finished_q <= 1'b0;
      failed_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      key_pos_q  <= key_pos_d;
      colon_q    <= colon_d;
      qc_q       <= qc_d;
      head_cnt_q <= head_cnt_d;
      opened_q   <= opened_d;
      finished_q <= finished_d;
      failed_q   <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quad_we) begin
      quad_q[qc_q] <= norm;
    end
  end

endmodule

// ===== hw/rtl/jbfe_back.sv =====
// Result sequencer: head store, format tag, byte bursts and the result queue
`timescale 1ns / 1ps
module jbfe_back
  import jbfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_vld_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] format_o,
  output logic [3:0] status_o,
  output logic       last_o
);

  logic [7:0]          head_q [HeadDepth];
  step_e               step_q, step_d, step_cur, step_nx;
  logic [HeadIdxW-1:0] idx_q, idx_d, idx_cur, idx_nx;
  logic                fresh_q, fresh_d;
  logic                emit, done, adv, head_we;
  res_t                res;
  logic [HeadCntW-1:0] dump;
  format_e             fmt;

  res_t                res_q [ResDepth];
  logic [ResPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0]  cnt_q, cnt_d;
  logic                res_full, res_push, res_pop;

  assign dump = HeadCntW'(cmd_i.base + HeadCntW'(cmd_i.nbytes));

  always_comb begin
    fmt = FMT_BIN;
    if (dump >= HeadCntW'(3) && head_q[0] == MAGIC_FF && head_q[1] == MAGIC_D8 &&
        head_q[2] == MAGIC_FF) begin
      fmt = FMT_JPG;
    end else if (dump >= HeadCntW'(4) && head_q[0] == MAGIC_89 && head_q[1] == MAGIC_P &&
                 head_q[2] == MAGIC_N && head_q[3] == MAGIC_G) begin
      fmt = FMT_PNG;
    end else if (dump >= HeadCntW'(4) && head_q[0] == MAGIC_R && head_q[1] == MAGIC_I &&
                 head_q[2] == MAGIC_F && head_q[3] == MAGIC_F) begin
      fmt = FMT_WEBP;
    end
  end

  always_comb begin
    if (!fresh_q) step_cur = step_q;
    else if (cmd_i.op != OP_PLAIN) step_cur = STEP_WRITE;
    else if (cmd_i.nbytes != 2'd0) step_cur = STEP_BYTE;
    else step_cur = STEP_STATUS;
    idx_cur = fresh_q ? '0 : idx_q;
  end

  // outputs of the sequencer step
  always_comb begin
    emit    = 1'b0;
    done    = 1'b0;
    head_we = 1'b0;
    res     = '0;
    step_nx = step_cur;
    idx_nx  = idx_cur;
    if (cmd_vld_i) begin
      unique case (step_cur)
        STEP_WRITE: begin
          head_we = 1'b1;
          idx_nx  = '0;
          if (cmd_i.op == OP_OPEN) step_nx = STEP_TAG;
          else if (cmd_i.stat_vld) step_nx = STEP_STATUS;
          else done = 1'b1;
        end
        STEP_TAG: begin
          emit     = 1'b1;
          res.kind = KIND_TAG;
          res.fmt  = fmt;
          step_nx  = STEP_HEAD;
          idx_nx   = '0;
        end
        STEP_HEAD: begin
          emit     = 1'b1;
          res.kind = KIND_BYTE;
          res.data = head_q[idx_cur];
          idx_nx   = HeadIdxW'(idx_cur + 1'b1);
          if ({1'b0, idx_cur} == HeadCntW'(dump - 1'b1)) begin
            if (cmd_i.stat_vld) step_nx = STEP_STATUS;
            else begin
              done     = 1'b1;
              res.last = 1'b1;
            end
          end
        end
        STEP_BYTE: begin
          emit     = 1'b1;
          res.kind = KIND_BYTE;
          res.data = cmd_i.bytes[idx_cur[1:0]];
          idx_nx   = HeadIdxW'(idx_cur + 1'b1);
          if (idx_cur[1:0] == 2'(cmd_i.nbytes - 1'b1)) begin
            if (cmd_i.stat_vld) step_nx = STEP_STATUS;
            else begin
              done     = 1'b1;
              res.last = 1'b1;
            end
          end
        end
        STEP_STATUS: begin
          emit     = 1'b1;
          res.kind = KIND_STATUS;
          res.stat = cmd_i.stat;
          res.last = 1'b1;
          done     = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign adv       = cmd_vld_i && (!emit || !res_full);
  assign cmd_pop_o = adv && done;
  assign res_push  = emit && adv;

  // next sequencer state
  always_comb begin
    step_d  = step_q;
    idx_d   = idx_q;
    fresh_d = fresh_q;
    if (adv) begin
      fresh_d = done;
      step_d  = step_nx;
      idx_d   = idx_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_WRITE;
      idx_q   <= '0;
      fresh_q <= 1'b1;
    end else begin
      step_q  <= step_d;
      idx_q   <= idx_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we && adv) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cmd_i.nbytes) begin
          head_q[HeadIdxW'(cmd_i.base + HeadCntW'(i))] <= cmd_i.bytes[i];
        end
      end
    end
  end

  assign res_full = (cnt_q == ResCntW'(ResDepth));
  assign empty_o  = (cnt_q == '0);
  assign res_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (res_push && !res_pop) cnt_d = ResCntW'(cnt_q + 1'b1);
    else if (res_pop && !res_push) cnt_d = ResCntW'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (res_push) wr_ptr_q <= ResPtrW'(wr_ptr_q + 1'b1);
      if (res_pop) rd_ptr_q <= ResPtrW'(rd_ptr_q + 1'b1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[wr_ptr_q] <= res;
    end
  end

  assign out_kind_o = res_q[rd_ptr_q].kind;
  assign out_byte_o = res_q[rd_ptr_q].data;
  assign format_o   = res_q[rd_ptr_q].fmt;
  assign status_o   = res_q[rd_ptr_q].stat;
  assign last_o     = res_q[rd_ptr_q].last;

endmodule

// ===== hw/rtl/json_base64_field_extractor_core.sv =====
// Top level of the base64 field extractor: front, command queue and back
//
//  channel   | direction | handshake         | payload
//  request   | in        | push / full       | kind_i, body_byte_i
//  result    | out       | empty / pop       | out_kind_o, out_byte_o, format_o, status_o,
//            |           |                   | last_o
//
//  One request a cycle is taken while the four-entry command queue has room.
//  The back sequencer delivers one result a cycle, while it has room, into a four-entry
//  result queue; a request that writes the head store first takes a head write step, and
//  one that fills it then gives its tag and held bytes (up to twelve results in all).
//  Reset clears all control state; the head store and quad buffer need no clearing.
//  A full result queue stalls the sequencer, which in turn lets the command queue fill.
`timescale 1ns / 1ps
module json_base64_field_extractor_core
  import jbfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       kind_i,
  input  logic [7:0] body_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] format_o,
  output logic [3:0] status_o,
  output logic       last_o
);

  logic in_vld;
  logic fr_cmd_vld;
  cmd_t fr_cmd;
  logic q_vld;
  cmd_t q_cmd;
  logic q_pop;

  assign in_vld = push && !full;

  jbfe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (in_vld),
    .kind_i    (kind_i),
    .byte_i    (body_byte_i),
    .cmd_vld_o (fr_cmd_vld),
    .cmd_o     (fr_cmd)
  );

  jbfe_cmd_queue u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_cmd_vld),
    .cmd_i  (fr_cmd),
    .full_o (full),
    .vld_o  (q_vld),
    .cmd_o  (q_cmd),
    .pop_i  (q_pop)
  );

  jbfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (q_vld),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_kind_o (out_kind_o),
    .out_byte_o (out_byte_o),
    .format_o   (format_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

endmodule

// ===== hw/rtl/jbfe_checker.sv =====
// Port-level checks of the base64 field extractor and their bind
`timescale 1ns / 1ps
`include "json_base64_field_extractor_core_assert.svh"
module jbfe_checker
  import jbfe_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_byte_o,
  input logic       last_o
);

  `JBFE_ASSERT_IMP(a_status_is_last, !empty && out_kind_o == KIND_STATUS, last_o)
  `JBFE_ASSERT_IMP(a_tag_not_last, !empty && out_kind_o == KIND_TAG, !last_o)
  `JBFE_ASSERT_NXT(a_tag_then_byte, pop && !empty && out_kind_o == KIND_TAG, empty || out_kind_o == KIND_BYTE)
  `JBFE_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(out_byte_o))

endmodule

bind json_base64_field_extractor_core jbfe_checker u_jbfe_checker (.*);

// ===== tb/sv/json_base64_field_extractor_core_tb.sv =====
// Self-checking testbench of the base64 field extractor: directed table, random bodies, predictor
`timescale 1ns / 1ps
module json_base64_field_extractor_core_tb;
  import jbfe_pkg::*;

  localparam int RandomItems = 400;
  localparam int Third       = (26 + RandomItems) / 3;
  localparam int NumRows     = 26;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       typed;
    status_e    stat;
  } row_t;

  typedef enum int {
    SC_CLEAN,
    SC_NO_KEY,
    SC_NO_COLON,
    SC_NULL,
    SC_NOT_STRING,
    SC_BAD_CHAR,
    SC_BAD_LENGTH,
    SC_DECODE,
    SC_CUT_SHORT
  } scenario_e;

  localparam row_t Directed [NumRows] = '{
    '{1'b1, 8'hFF, 1'b1, STAT_NO_KEY},
    '{1'b0, CH_QUOTE, 1'b0, STAT_OK},
    '{1'b0, CH_QUOTE, 1'b0, STAT_OK},
    '{1'b0, 8'h62, 1'b0, STAT_OK},
    '{1'b0, 8'h36, 1'b0, STAT_OK},
    '{1'b0, 8'h34, 1'b0, STAT_OK},
    '{1'b0, CH_UNDER, 1'b0, STAT_OK},
    '{1'b0, 8'h6A, 1'b0, STAT_OK},
    '{1'b0, 8'h73, 1'b0, STAT_OK},
    '{1'b0, 8'h6F, 1'b0, STAT_OK},
    '{1'b0, CH_LC_N, 1'b0, STAT_OK},
    '{1'b0, CH_QUOTE, 1'b0, STAT_OK},
    '{1'b0, CH_SPACE, 1'b0, STAT_OK},
    '{1'b0, CH_COLON, 1'b0, STAT_OK},
    '{1'b0, CH_TAB, 1'b0, STAT_OK},
    '{1'b0, CH_QUOTE, 1'b0, STAT_OK},
    '{1'b0, CH_MINUS, 1'b0, STAT_OK},
    '{1'b0, CH_UNDER, 1'b0, STAT_OK},
    '{1'b0, CH_EQ, 1'b0, STAT_OK},
    '{1'b0, CH_EQ, 1'b0, STAT_OK},
    '{1'b0, CH_CR, 1'b0, STAT_OK},
    '{1'b0, CH_QUOTE, 1'b1, STAT_TRUNCATED},
    '{1'b0, 8'h5A, 1'b0, STAT_OK},
    '{1'b1, 8'h00, 1'b0, STAT_OK},
    '{1'b0, 8'h00, 1'b0, STAT_OK},
    '{1'b1, 8'h80, 1'b1, STAT_NO_KEY}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       kind_i = 1'b0;
  logic [7:0] body_byte_i = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic [1:0] format_o;
  logic [3:0] status_o;
  logic       last_o;

  res_t      pending_results[$];
  res_t      step_out[$];
  int        mismatches = 0;
  int        n_sent = 0;
  int        src_idle = 16;
  int        snk_idle = 72;
  scenario_e next_fault = SC_NO_KEY;

  phase_e     ph;
  int         key_pos;
  logic       colon_ok;
  logic [7:0] quad[4];
  int         qn;
  logic [7:0] head[HeadDepth];
  int         hn;
  logic       opened;
  logic       done;
  logic       failed;

  json_base64_field_extractor_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .body_byte_i (body_byte_i),
    .empty       (empty),
    .pop         (pop),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .format_o    (format_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] key_at(input int idx);
    return key_char(4'(idx));
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  function automatic int b64_index(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) return int'(c) - 65;
    if (c inside {[8'h61:8'h7A]}) return int'(c) - 71;
    if (c inside {[8'h30:8'h39]}) return int'(c) + 4;
    if (c == CH_PLUS) return 62;
    if (c == CH_SLASH) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v - 26);
    if (v < 62) return 8'h30 + 8'(v - 52);
    return (v == 62) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic format_e sniff_format();
    if (hn >= 3 && head[0] == MAGIC_FF && head[1] == MAGIC_D8 && head[2] == MAGIC_FF)
      return FMT_JPG;
    if (hn >= 4 && head[0] == MAGIC_89 && head[1] == MAGIC_P && head[2] == MAGIC_N &&
        head[3] == MAGIC_G)
      return FMT_PNG;
    if (hn >= 4 && head[0] == MAGIC_R && head[1] == MAGIC_I && head[2] == MAGIC_F &&
        head[3] == MAGIC_F)
      return FMT_WEBP;
    return FMT_BIN;
  endfunction

  task automatic emit(input out_kind_e k, input logic [7:0] d, input format_e f,
                      input status_e s);
    step_out.push_back('{k, d, f, s, 1'b0});
  endtask

  task automatic abort_body(input status_e s);
    failed = 1'b1;
    emit(KIND_STATUS, 8'h00, FMT_JPG, s);
  endtask

  task automatic clear_state();
    ph = PH_HUNT;
    key_pos = 0;
    colon_ok = 1'b0;
    qn = 0;
    hn = 0;
    opened = 1'b0;
    done = 1'b0;
    failed = 1'b0;
  endtask

  task automatic decode_quad(output logic ok);
    int eq, v, len, copy, i;
    logic seen;
    logic [23:0] w;
    logic [7:0] b[3];
    qn = 0;
    eq = 0;
    seen = 1'b0;
    w = '0;
    ok = 1'b1;
    for (i = 0; i < 4; i++) begin
      v = 0;
      if (quad[i] == CH_EQ) begin
        eq++;
        seen = 1'b1;
      end else begin
        v = b64_index(quad[i]);
        if (seen || v < 0) ok = 1'b0;
      end
      w = {w[17:0], 6'(v)};
    end
    if (!ok || eq > 2) begin
      ok = 1'b0;
      return;
    end
    b[0] = w[23:16];
    b[1] = w[15:8];
    b[2] = w[7:0];
    len = 3 - eq;
    if (opened) begin
      for (i = 0; i < len; i++) emit(KIND_BYTE, b[i], FMT_JPG, STAT_OK);
      return;
    end
    copy = (hn + len > HeadDepth) ? HeadDepth - hn : len;
    for (i = 0; i < copy; i++) head[hn + i] = b[i];
    hn += copy;
    if (hn >= HeadThreshold) begin
      emit(KIND_TAG, 8'h00, sniff_format(), STAT_OK);
      for (i = 0; i < hn && i < HeadDepth; i++) emit(KIND_BYTE, head[i], FMT_JPG, STAT_OK);
      for (i = copy; i < len; i++) emit(KIND_BYTE, b[i], FMT_JPG, STAT_OK);
      opened = 1'b1;
    end
  endtask

  task automatic value_char(input logic [7:0] c_in);
    logic [7:0] c;
    logic ok;
    c = c_in;
    if (c == CH_QUOTE) begin
      if (qn == 1) begin
        abort_body(STAT_BAD_LENGTH);
        return;
      end
      if (qn != 0) begin
        while (qn < 4) begin
          quad[qn] = CH_EQ;
          qn++;
        end
        decode_quad(ok);
        if (!ok) begin
          abort_body(STAT_DECODE_ERR);
          return;
        end
      end
      done = 1'b1;
      emit(KIND_STATUS, 8'h00, FMT_JPG, opened ? STAT_OK : STAT_TRUNCATED);
      return;
    end
    if (is_white(c)) return;
    if (c == CH_MINUS) c = CH_PLUS;
    else if (c == CH_UNDER) c = CH_SLASH;
    else if (c != CH_EQ && b64_index(c) < 0) begin
      abort_body(STAT_BAD_CHAR);
      return;
    end
    quad[qn] = c;
    qn++;
    if (qn >= 4) begin
      decode_quad(ok);
      if (!ok) abort_body(STAT_DECODE_ERR);
    end
  endtask

  task automatic body_char(input logic [7:0] c);
    if (ph == PH_HUNT) begin
      if (key_pos < 10 && c == key_at(key_pos)) begin
        key_pos++;
        if (key_pos >= 10) begin
          ph = PH_AFTER;
          colon_ok = 1'b0;
          key_pos = 0;
        end
      end else begin
        key_pos = (c == CH_QUOTE) ? 1 : 0;
      end
    end else if (ph == PH_AFTER) begin
      if (is_white(c)) return;
      if (!colon_ok) begin
        if (c != CH_COLON) abort_body(STAT_NO_COLON);
        else colon_ok = 1'b1;
      end else if (c == CH_LC_N) begin
        abort_body(STAT_NULL);
      end else if (c != CH_QUOTE) begin
        abort_body(STAT_NOT_STRING);
      end else begin
        ph = PH_VALUE;
      end
    end else begin
      value_char(c);
    end
  endtask

  task automatic extract_step(input logic k, input logic [7:0] c);
    step_out.delete();
    if (k) begin
      if (!failed && !done)
        emit(KIND_STATUS, 8'h00, FMT_JPG, (ph == PH_VALUE) ? STAT_TRUNCATED : STAT_NO_KEY);
      clear_state();
    end else if (!failed && !done) begin
      body_char(c);
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endtask

  task automatic send(input logic k, input logic [7:0] c, input logic typed,
                      input status_e s);
    if (n_sent < Third) begin
      src_idle = 16;
      snk_idle = 72;
    end else if (n_sent < 2 * Third) begin
      src_idle = 72;
      snk_idle = 16;
    end else begin
      src_idle = 0;
      snk_idle = 0;
    end
    while ($urandom_range(0, 99) < src_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    kind_i <= k;
    body_byte_i <= c;
    do @(posedge clk_i); while (full);
    n_sent++;
    extract_step(k, c);
    if (typed) begin
      step_out.delete();
      step_out.push_back('{KIND_STATUS, 8'h00, FMT_JPG, s, 1'b1});
    end
    foreach (step_out[j]) pending_results.push_back(step_out[j]);
  endtask

  task automatic send_byte(input logic [7:0] c);
    send(1'b0, c, 1'b0, STAT_OK);
  endtask

  task automatic send_end();
    send(1'b1, 8'($urandom()), 1'b0, STAT_OK);
  endtask

  task automatic send_ws(input int n);
    int i;
    logic [7:0] c;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0:       c = CH_SPACE;
        1:       c = CH_TAB;
        2:       c = CH_LF;
        default: c = CH_CR;
      endcase
      send_byte(c);
    end
  endtask

  task automatic drain_and_end();
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom()));
    send_end();
  endtask

  task automatic random_body();
    scenario_e sc;
    int len, i, k, pos;
    logic [7:0] raw[$];
    logic [7:0] val[$];
    logic [23:0] w;
    logic [7:0] c;
    logic keep_pad;
    if ($urandom_range(0, 99) < 45) begin
      sc = SC_CLEAN;
    end else begin
      sc = next_fault;
      next_fault = (next_fault == SC_CUT_SHORT) ? SC_NO_KEY : scenario_e'(int'(next_fault) + 1);
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
    if (sc == SC_NO_KEY) begin
      k = $urandom_range(2, 7);
      for (i = 0; i < k; i++) send_byte(key_at(i));
      repeat ($urandom_range(2, 8)) send_byte(8'($urandom()));
      send_end();
      return;
    end
    if ($urandom_range(0, 3) == 0) send_byte(CH_QUOTE);
    for (i = 0; i < 10; i++) send_byte(key_at(i));
    send_ws($urandom_range(0, 2));
    if (sc == SC_NO_COLON) begin
      do c = 8'($urandom()); while (is_white(c) || c == CH_COLON);
      send_byte(c);
      drain_and_end();
      return;
    end
    send_byte(CH_COLON);
    send_ws($urandom_range(0, 2));
    if (sc == SC_NULL) begin
      send_byte(CH_LC_N);
      drain_and_end();
      return;
    end
    if (sc == SC_NOT_STRING) begin
      do c = 8'($urandom()); while (is_white(c) || c == CH_QUOTE || c == CH_LC_N);
      send_byte(c);
      drain_and_end();
      return;
    end
    send_byte(CH_QUOTE);

    if (sc == SC_BAD_LENGTH) len = 3 * $urandom_range(0, 4);
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(16, 36);
    else len = $urandom_range((sc == SC_DECODE) ? 3 : 0, 14);
    for (i = 0; i < len + 2; i++) raw.push_back((i < len) ? 8'($urandom()) : 8'h00);
    if (len >= 4 && $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          raw[0] = MAGIC_FF;
          raw[1] = MAGIC_D8;
          raw[2] = MAGIC_FF;
        end
        1: begin
          raw[0] = MAGIC_89;
          raw[1] = MAGIC_P;
          raw[2] = MAGIC_N;
          raw[3] = MAGIC_G;
        end
        default: begin
          raw[0] = MAGIC_R;
          raw[1] = MAGIC_I;
          raw[2] = MAGIC_F;
          raw[3] = MAGIC_F;
        end
      endcase
    end
    keep_pad = 1'($urandom_range(0, 1));
    for (i = 0; i < len; i += 3) begin
      k = (len - i >= 3) ? 3 : len - i;
      w = {raw[i], raw[i + 1], raw[i + 2]};
      for (pos = 0; pos <= k; pos++) val.push_back(b64_char(w[23 - 6 * pos -: 6]));
      if (keep_pad) repeat (3 - k) val.push_back(CH_EQ);
    end
    for (i = 0; i < val.size(); i++) begin
      if (val[i] == CH_PLUS && $urandom_range(0, 1)) val[i] = CH_MINUS;
      else if (val[i] == CH_SLASH && $urandom_range(0, 1)) val[i] = CH_UNDER;
    end
    if (sc == SC_BAD_LENGTH) val.push_back(b64_char(6'($urandom())));
    if (sc == SC_DECODE)
      val[4 * $urandom_range(0, val.size() / 4 - 1) + $urandom_range(0, 1)] = CH_EQ;
    if (sc == SC_BAD_CHAR) begin
      do c = 8'($urandom());
      while (b64_index(c) >= 0 || is_white(c) ||
             c inside {CH_EQ, CH_MINUS, CH_UNDER, CH_QUOTE});
      val.insert($urandom_range(0, val.size()), c);
    end

    k = (sc == SC_CUT_SHORT) ? $urandom_range(0, val.size()) : val.size();
    for (i = 0; i < k; i++) begin
      if ($urandom_range(0, 7) == 0) send_ws(1);
      send_byte(val[i]);
    end
    if (sc == SC_CUT_SHORT) begin
      send_end();
      return;
    end
    send_byte(CH_QUOTE);
    drain_and_end();
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: kind %0d byte %02h fmt %0d stat %0d last %0b",
                 $time, out_kind_o, out_byte_o, format_o, status_o, last_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if ({out_kind_o, out_byte_o, format_o, status_o, last_o} !== want) begin
          $display("%0t: expected kind %0d byte %02h fmt %0d stat %0d last %0b", $time,
                   want.kind, want.data, want.fmt, want.stat, want.last);
          $display("%0t:   actual kind %0d byte %02h fmt %0d stat %0d last %0b", $time,
                   out_kind_o, out_byte_o, format_o, status_o, last_o);
          mismatches++;
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= snk_idle);
  end

  initial begin
    int r;
    clear_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (r = 0; r < NumRows; r++)
      send(Directed[r].kind, Directed[r].ch, Directed[r].typed, Directed[r].stat);
    while (n_sent < NumRows + RandomItems) random_body();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS json_base64_field_extractor_core");
    end else begin
      $display("FAIL json_base64_field_extractor_core");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL json_base64_field_extractor_core");
    $finish;
  end

endmodule
